// File: rtl/core/spdq_pkg.sv
// ----------------------------------------------------------------------------
// spdq_pkg
// Shared types and constants of the strict priority deque scheduler.
// ----------------------------------------------------------------------------
package spdq_pkg;

  localparam int ENTRY_W        = 8;
  localparam int DEF_LEVELS     = 2;
  localparam int DEF_DEPTH      = 16;

  typedef enum logic {
    ACT_ENQ = 1'b0,
    ACT_DEQ = 1'b1
  } action_t;

  typedef logic [ENTRY_W-1:0] entry_t;

  typedef struct packed {
    logic found;
    logic prio;
    logic overflow;
  } spdq_resp_t;

endpackage

// File: rtl/core/spdq_req_if.sv
// ----------------------------------------------------------------------------
// spdq_req_if
// Request channel: scheduler command with valid/ready handshake.
// ----------------------------------------------------------------------------
interface spdq_req_if;
  import spdq_pkg::*;

  logic   valid;
  logic   ready;
  logic   action;
  entry_t entry_id;
  logic   prio_level;
  logic   resume;

  modport source (output valid, action, entry_id, prio_level, resume, input ready);
  modport sink   (input valid, action, entry_id, prio_level, resume, output ready);
endinterface

// File: rtl/core/spdq_rsp_if.sv
// ----------------------------------------------------------------------------
// spdq_rsp_if
// Response channel: one scheduler result per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface spdq_rsp_if;
  import spdq_pkg::*;

  logic   valid;
  logic   ready;
  logic   found;
  entry_t out_entry;
  logic   out_prio;
  logic   overflow;

  modport source (output valid, found, out_entry, out_prio, overflow, input ready);
  modport sink   (input valid, found, out_entry, out_prio, overflow, output ready);
endinterface

// File: rtl/core/strict_priority_deque_scheduler.sv
// ----------------------------------------------------------------------------
// strict_priority_deque_scheduler
// Strict priority scheduler over one bounded deque of entry ids per level.
//
//   channel  dir  role    fields
//   req      in   sink    action, entry_id, prio_level, resume
//   rsp      out  source  found, out_entry, out_prio, overflow
//
// one request accepted per cycle while req.ready is high; its response is valid the cycle after
// the response entry comes from the registered read of the entry store
// rst clears the head pointers and fill counts, the store is not cleared
// req.ready drops only while a response is held by rsp.ready low
// ----------------------------------------------------------------------------
module strict_priority_deque_scheduler #(
  parameter int PRIORITY_LEVELS = spdq_pkg::DEF_LEVELS,
  parameter int QUEUE_DEPTH     = spdq_pkg::DEF_DEPTH
) (
  input logic       clk,
  input logic       rst,
  spdq_req_if.sink  req,
  spdq_rsp_if.source rsp
);
  import spdq_pkg::*;

  localparam int LW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int AW = LW + PW;

  logic       accept;
  logic       rsp_valid;
  spdq_resp_t resp;
  spdq_resp_t resp_q;
  logic       ram_we;
  logic       ram_re;
  logic [AW-1:0] ram_addr;
  entry_t     ram_rdata;

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  spdq_ctrl #(
    .PRIORITY_LEVELS (PRIORITY_LEVELS),
    .QUEUE_DEPTH     (QUEUE_DEPTH),
    .AW              (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .action     (req.action),
    .prio_level (req.prio_level),
    .resume     (req.resume),
    .ram_we     (ram_we),
    .ram_re     (ram_re),
    .ram_addr   (ram_addr),
    .resp       (resp)
  );

  spdq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (2 ** AW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (req.entry_id),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      resp_q <= resp;
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.found     = resp_q.found;
  assign rsp.out_entry = resp_q.found ? ram_rdata : '0;
  assign rsp.out_prio  = resp_q.prio;
  assign rsp.overflow  = resp_q.overflow;

endmodule

// File: rtl/core/spdq_ram.sv
// ----------------------------------------------------------------------------
// spdq_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module spdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: rtl/core/spdq_ctrl.sv
// ----------------------------------------------------------------------------
// spdq_ctrl
// Per-level head pointers and fill counts, priority pick and store access.
// ----------------------------------------------------------------------------
module spdq_ctrl #(
  parameter int PRIORITY_LEVELS = spdq_pkg::DEF_LEVELS,
  parameter int QUEUE_DEPTH     = spdq_pkg::DEF_DEPTH,
  parameter int AW              = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 action,
  input  logic                 prio_level,
  input  logic                 resume,
  output logic                 ram_we,
  output logic                 ram_re,
  output logic [AW-1:0]        ram_addr,
  output spdq_pkg::spdq_resp_t resp
);
  import spdq_pkg::*;

  localparam int LW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int OW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = PW + 1;

  logic [PW-1:0] head_ptr      [PRIORITY_LEVELS];
  logic [PW-1:0] head_ptr_next [PRIORITY_LEVELS];
  logic [OW-1:0] occupancy      [PRIORITY_LEVELS];
  logic [OW-1:0] occupancy_next [PRIORITY_LEVELS];

  logic [PRIORITY_LEVELS-1:0] nonempty;
  logic          is_deq;
  logic          deq_any;
  logic [LW-1:0] deq_lvl;
  logic [LW-1:0] enq_lvl;
  logic          enq_full;
  logic [SW-1:0] tail_sum;
  logic [PW-1:0] tail_pos;
  logic [PW-1:0] head_dec;
  logic [PW-1:0] head_inc;
  logic [PW-1:0] deq_head;
  logic [PW-1:0] enq_head;
  logic [LW-1:0] acc_lvl;
  logic [PW-1:0] acc_pos;

  assign is_deq = (action_t'(action) == ACT_DEQ);

  // highest non-empty level
  always_comb begin
    deq_lvl = '0;
    for (int i = 0; i < PRIORITY_LEVELS; i++) begin
      nonempty[i] = (occupancy[i] != '0);
      if (nonempty[i]) begin
        deq_lvl = LW'(i);
      end
    end
    deq_any = |nonempty;
  end

  // out-of-range level saturates to the top level
  always_comb begin
    if (int'(prio_level) >= PRIORITY_LEVELS) begin
      enq_lvl = LW'(PRIORITY_LEVELS - 1);
    end else begin
      enq_lvl = LW'(prio_level);
    end
  end

  assign enq_full = (occupancy[enq_lvl] == OW'(QUEUE_DEPTH));
  assign enq_head = head_ptr[enq_lvl];
  assign deq_head = head_ptr[deq_lvl];

  always_comb begin
    tail_sum = SW'(enq_head) + SW'(occupancy[enq_lvl]);
    if (tail_sum >= SW'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - SW'(QUEUE_DEPTH);
    end
    tail_pos = tail_sum[PW-1:0];
  end

  assign head_dec = (enq_head == '0) ? PW'(QUEUE_DEPTH - 1) : enq_head - PW'(1);
  assign head_inc = (deq_head == PW'(QUEUE_DEPTH - 1)) ? '0 : deq_head + PW'(1);

  always_comb begin
    if (is_deq) begin
      acc_lvl = deq_lvl;
      acc_pos = deq_head;
    end else begin
      acc_lvl = enq_lvl;
      acc_pos = resume ? head_dec : tail_pos;
    end
  end

  assign ram_addr = AW'({acc_lvl, acc_pos});
  assign ram_we   = accept && !is_deq && !enq_full;
  assign ram_re   = accept && is_deq && deq_any;

  assign resp.found    = is_deq && deq_any;
  assign resp.prio     = is_deq && deq_any && deq_lvl[0];
  assign resp.overflow = !is_deq && enq_full;

  always_comb begin
    for (int i = 0; i < PRIORITY_LEVELS; i++) begin
      head_ptr_next[i]  = head_ptr[i];
      occupancy_next[i] = occupancy[i];
    end
    if (ram_we) begin
      occupancy_next[enq_lvl] = occupancy[enq_lvl] + OW'(1);
      if (resume) begin
        head_ptr_next[enq_lvl] = head_dec;
      end
    end else if (ram_re) begin
      occupancy_next[deq_lvl] = occupancy[deq_lvl] - OW'(1);
      head_ptr_next[deq_lvl]  = head_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PRIORITY_LEVELS; i++) begin
        head_ptr[i]  <= '0;
        occupancy[i] <= '0;
      end
    end else begin
      for (int i = 0; i < PRIORITY_LEVELS; i++) begin
        head_ptr[i]  <= head_ptr_next[i];
        occupancy[i] <= occupancy_next[i];
      end
    end
  end

`ifndef SYNTHESIS
  a_we_re_excl : assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("store written and read in one cycle");

  a_empty_miss : assert property (@(posedge clk) disable iff (rst)
    (accept && is_deq && !resp.found) |-> (nonempty == '0))
    else $error("dequeue missed a non-empty level");

  a_ovf_full : assert property (@(posedge clk) disable iff (rst)
    (accept && resp.overflow) |-> (occupancy_next[enq_lvl] == occupancy[enq_lvl]))
    else $error("dropped enqueue changed the fill count");

  for (genvar g = 0; g < PRIORITY_LEVELS; g++) begin : g_occ_chk
    a_occ_bound : assert property (@(posedge clk) disable iff (rst)
      occupancy[g] <= OW'(QUEUE_DEPTH))
      else $error("fill count beyond queue depth");
  end
`endif

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the strict priority deque scheduler. Directed
// requests cover empty dequeue, head and tail insert on both levels and the
// extreme ids. Random phases then favour enqueue, dequeue or neither, so the
// deques wrap, fill up and overflow. Every request is predicted by the
// tracker class, and each response is compared field by field in order.
// Both channels stall in random bursts. One long receiver hold-off backs up
// the request channel.
// ----------------------------------------------------------------------------
module tb_top;
  import spdq_pkg::*;

  localparam int LEVELS      = DEF_LEVELS;
  localparam int DEPTH       = DEF_DEPTH;
  localparam int NUM_REQS    = 950;
  localparam int TAIL_REQS   = 120;
  localparam int HOLD_CYCLES = 80;
  localparam int HOLD_AFTER  = 300;
  localparam int QUIET_LIMIT = 1000;
  localparam int MAX_PRINTS  = 40;

  typedef struct {
    logic   found;
    entry_t entry;
    logic   prio;
    logic   overflow;
  } sched_rsp_t;

  class deque_tracker;
    entry_t     store [LEVELS][DEPTH];
    int         head [LEVELS];
    int         fill [LEVELS];
    sched_rsp_t expected [$];
    int         errors;

    function new();
      for (int l = 0; l < LEVELS; l++) begin
        head[l] = 0;
        fill[l] = 0;
      end
      errors = 0;
    endfunction

    task report(input string msg);
      if (errors < MAX_PRINTS) begin
        $display("%0t mismatch: %s", $realtime, msg);
      end
      errors++;
    endtask

    function void note_request(input action_t act, input entry_t id, input logic lvl,
                               input logic at_head);
      sched_rsp_t r;
      int         slot;
      int         q;
      r = '{found: 1'b0, entry: '0, prio: 1'b0, overflow: 1'b0};
      q = (lvl >= LEVELS) ? LEVELS - 1 : lvl;
      if (act == ACT_ENQ) begin
        if (fill[q] == DEPTH) begin
          r.overflow = 1'b1;
        end else begin
          if (at_head) begin
            head[q] = (head[q] + DEPTH - 1) % DEPTH;
            slot = head[q];
          end else begin
            slot = (head[q] + fill[q]) % DEPTH;
          end
          store[q][slot] = id;
          fill[q]++;
        end
      end else begin
        for (int l = LEVELS - 1; l >= 0; l--) begin
          if (!r.found && fill[l] != 0) begin
            r.found = 1'b1;
            r.entry = store[l][head[l]];
            r.prio  = l[0];
            head[l] = (head[l] + 1) % DEPTH;
            fill[l]--;
          end
        end
      end
      expected.push_back(r);
    endfunction

    task check_response(input logic found, input entry_t id, input logic lvl,
                        input logic overflow);
      sched_rsp_t r;
      if (expected.size() == 0) begin
        report("response with no request outstanding");
      end else begin
        r = expected.pop_front();
        if (found !== r.found)
          report($sformatf("found got %b want %b", found, r.found));
        if (id !== r.entry)
          report($sformatf("out_entry got %h want %h", id, r.entry));
        if (lvl !== r.prio)
          report($sformatf("out_prio got %b want %b", lvl, r.prio));
        if (overflow !== r.overflow)
          report($sformatf("overflow got %b want %b", overflow, r.overflow));
      end
    endtask

    function int outstanding();
      return expected.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  spdq_req_if req_if ();
  spdq_rsp_if rsp_if ();

  deque_tracker trk = new();

  int rsp_count;
  bit quiet_tail;

  strict_priority_deque_scheduler #(
    .PRIORITY_LEVELS(LEVELS),
    .QUEUE_DEPTH    (DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic issue(input action_t act, input entry_t id, input logic lvl,
                       input logic at_head);
    req_if.valid      <= 1'b1;
    req_if.action     <= act;
    req_if.entry_id   <= id;
    req_if.prio_level <= lvl;
    req_if.resume     <= at_head;
    do @(posedge clk); while (!req_if.ready);
    trk.note_request(act, id, lvl, at_head);
  endtask

  task automatic pause(input int n);
    req_if.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic issue_random(input int enq_pct, input bit gaps);
    action_t act;
    if (gaps && !quiet_tail && $urandom_range(0, 7) == 0) pause($urandom_range(1, 5));
    act = ($urandom_range(1, 100) <= enq_pct) ? ACT_ENQ : ACT_DEQ;
    issue(act, entry_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
          $urandom_range(0, 3) == 0);
  endtask

  // stimulus
  initial begin
    int sent;
    int seg_len;
    int enq_pct;
    bit gaps;
    rst               <= 1'b1;
    req_if.valid      <= 1'b0;
    req_if.action     <= ACT_ENQ;
    req_if.entry_id   <= '0;
    req_if.prio_level <= 1'b0;
    req_if.resume     <= 1'b0;
    quiet_tail         = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed
    issue(ACT_DEQ, 8'hFF, 1'b1, 1'b1);
    issue(ACT_ENQ, 8'h00, 1'b0, 1'b0);
    issue(ACT_ENQ, 8'hFF, 1'b0, 1'b1);
    issue(ACT_ENQ, 8'hA5, 1'b1, 1'b0);
    issue(ACT_ENQ, 8'h5A, 1'b1, 1'b1);
    issue(ACT_ENQ, 8'h3C, 1'b0, 1'b0);
    issue(ACT_DEQ, 8'h00, 1'b0, 1'b0);
    issue(ACT_DEQ, 8'h00, 1'b0, 1'b0);
    issue(ACT_ENQ, 8'h81, 1'b1, 1'b1);
    issue(ACT_DEQ, 8'h00, 1'b0, 1'b0);
    issue(ACT_DEQ, 8'h00, 1'b0, 1'b0);
    issue(ACT_DEQ, 8'h00, 1'b0, 1'b0);
    issue(ACT_DEQ, 8'h00, 1'b0, 1'b0);
    issue(ACT_DEQ, 8'h7E, 1'b0, 1'b1);
    sent = 14;

    // random phases, biased so that deques run full and empty
    while (sent < NUM_REQS) begin
      seg_len = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0: enq_pct = 15;
        1: enq_pct = 50;
        default: enq_pct = 90;
      endcase
      gaps = $urandom_range(0, 2) != 0;
      for (int i = 0; i < seg_len && sent < NUM_REQS; i++) begin
        if (NUM_REQS - sent <= TAIL_REQS) quiet_tail = 1'b1;
        issue_random(enq_pct, gaps);
        sent++;
      end
    end
    req_if.valid <= 1'b0;

    while (trk.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (trk.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // response side
  initial begin
    int stall_left;
    bit hold_done;
    stall_left    = 0;
    hold_done     = 1'b0;
    rsp_count     = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_if.valid && rsp_if.ready) begin
        trk.check_response(rsp_if.found, rsp_if.out_entry, rsp_if.out_prio,
                           rsp_if.overflow);
        rsp_count++;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (!quiet_tail && !hold_done && rsp_count >= HOLD_AFTER) begin
        hold_done     = 1'b1;
        stall_left    = HOLD_CYCLES - 1;
        rsp_if.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        stall_left    = $urandom_range(1, 5) - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // watchdog
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule

// File: filelist.f
rtl/core/spdq_pkg.sv
rtl/core/spdq_req_if.sv
rtl/core/spdq_rsp_if.sv
rtl/core/spdq_ram.sv
rtl/core/spdq_ctrl.sv
rtl/core/strict_priority_deque_scheduler.sv
test/tb_top.sv
